// File: hw/rtl/rj_pkg.sv
// Shared types, constants and the saturation helper of the radar Jacobian block.
package rj_pkg;

    localparam int RJ_FRAC_BITS = 16;
    localparam logic [15:0] RJ_GUARD_RESET = 16'd7;
    localparam int RJ_QDEPTH = 2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } rj_in_t;

    typedef struct packed {
        logic signed [31:0] d_range_d_px;
        logic signed [31:0] d_range_d_py;
        logic signed [31:0] d_bearing_d_px;
        logic signed [31:0] d_bearing_d_py;
        logic signed [31:0] d_rate_d_px;
        logic signed [31:0] d_rate_d_py;
        logic               near_zero;
    } rj_out_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [63:0] s;
        logic [63:0] c1;
        logic [63:0] cr;
        logic [31:0] apx;
        logic [31:0] apy;
        logic        npx;
        logic        npy;
        logic        ncr;
        logic        near;
    } rj_cls_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LAUNCH,
        BK_ROOT,
        BK_DIVR,
        BK_MUL,
        BK_HOLD
    } rj_state_t;

    // Applies a sign to a magnitude and clips it to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (m >= 64'h8000_0000) begin
                r = 32'h8000_0000;
            end else begin
                r = 32'(~m + 64'd1);
            end
        end else begin
            if (m > 64'h7FFF_FFFF) begin
                r = 32'h7FFF_FFFF;
            end else begin
                r = m[31:0];
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/rj_div.sv
// Restoring divider for 64-bit unsigned operands, one quotient bit per cycle.
module rj_div
    import rj_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [63:0] quo,
    output logic        done
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [64:0] trial;
    logic        ge;

    assign trial = {rem_reg, quo_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next = ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
        quo_next = {quo_reg[62:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo  = quo_reg;
    assign done = !busy_reg;

endmodule

// File: hw/rtl/rj_fifo.sv
// Two-entry queue that decouples the classifying front from the arithmetic back.
module rj_fifo
    import rj_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  rj_cls_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output rj_cls_t out_data
);

    localparam int AW = $clog2(RJ_QDEPTH);

    rj_cls_t         slot_reg [RJ_QDEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(RJ_QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(RJ_QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(RJ_QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= in_data;
        end
    end

endmodule

// File: hw/rtl/rj_front.sv
// Front part: takes states, forms magnitudes, squares and cross products, flags near zero.
module rj_front
    import rj_pkg::*;
#(
    parameter int FRAC_BITS = RJ_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rj_in_t      s_data,
    input  logic [15:0] guard,
    output logic        q_valid,
    input  logic        q_ready,
    output rj_cls_t     q_data
);

    logic               v1_reg, v2_reg;
    logic               adv1, adv2;
    logic [31:0]        apx_reg, apy_reg;
    logic               npx_reg, npy_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [63:0]        sqx_reg, sqy_reg;
    logic signed [63:0] p1_reg, p2_reg;
    logic               npx2_reg, npy2_reg;
    logic [31:0]        apx2_reg, apy2_reg;
    logic [31:0]        apx_next, apy_next;
    logic [63:0]        sum;

    assign adv2    = !v2_reg || q_ready;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    assign apx_next = s_data.pos_x[31] ? 32'(~s_data.pos_x + 32'sd1) : s_data.pos_x;
    assign apy_next = s_data.pos_y[31] ? 32'(~s_data.pos_y + 32'sd1) : s_data.pos_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            apx_reg <= apx_next;
            apy_reg <= apy_next;
            npx_reg <= s_data.pos_x[31];
            npy_reg <= s_data.pos_y[31];
            px_reg  <= s_data.pos_x;
            py_reg  <= s_data.pos_y;
            vx_reg  <= s_data.vel_x;
            vy_reg  <= s_data.vel_y;
        end
        if (adv2) begin
            sqx_reg  <= 64'(apx_reg) * 64'(apx_reg);
            sqy_reg  <= 64'(apy_reg) * 64'(apy_reg);
            p1_reg   <= 64'(vx_reg) * 64'(py_reg);
            p2_reg   <= 64'(vy_reg) * 64'(px_reg);
            apx2_reg <= apx_reg;
            apy2_reg <= apy_reg;
            npx2_reg <= npx_reg;
            npy2_reg <= npy_reg;
        end
    end

    assign sum = sqx_reg + sqy_reg;

    always_comb begin
        q_data.s   = sum;
        q_data.c1  = sum >> FRAC_BITS;
        q_data.apx = apx2_reg;
        q_data.apy = apy2_reg;
        q_data.npx = npx2_reg;
        q_data.npy = npy2_reg;
        q_data.ncr = p1_reg < p2_reg;
        q_data.cr  = (p1_reg < p2_reg) ? 64'(p2_reg - p1_reg) : 64'(p1_reg - p2_reg);
        q_data.near = (q_data.c1 == 64'd0) || (q_data.c1 < {48'd0, guard});
    end

    assign q_valid = v2_reg;

endmodule

// File: hw/rtl/rj_back.sv
// Back part: square root, five serial divisions and two serial products per item; near-zero items skip them.
module rj_back
    import rj_pkg::*;
#(
    parameter int FRAC_BITS = RJ_FRAC_BITS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  rj_cls_t q_data,
    output logic    m_valid,
    input  logic    m_ready,
    output rj_out_t m_data
);

    localparam int MW = 32 + FRAC_BITS;

    rj_state_t   state_reg, state_next;
    rj_cls_t     item_reg;
    logic [63:0] sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [5:0]  sq_cnt_reg;
    logic [63:0] d2_reg, d3_reg, a_reg, b_reg, wsh_reg;
    logic [MW-1:0] acc_a_reg, acc_b_reg, sa_a_reg, sa_b_reg;
    logic        ov_a_reg, ov_b_reg, sov_a_reg, sov_b_reg;
    logic [5:0]  mcnt_reg;
    logic        m_valid_reg;
    rj_out_t     m_data_reg;

    logic        q_pop, start_c1, start_r, mul_load, mul_run, out_load, sq_init, sq_run;
    logic [63:0] quo [3];
    logic [2:0]  ldone;
    logic [63:0] num_x, num_y, den_xy;
    logic [63:0] sq_try;
    logic [MW:0] sum_a, sum_b;
    logic [63:0] mag_a, mag_b;
    rj_out_t     res;

    assign num_x  = 64'(item_reg.apx) << FRAC_BITS;
    assign num_y  = 64'(item_reg.apy) << FRAC_BITS;
    assign den_xy = start_r ? sq_res_reg : item_reg.c1;

    rj_div u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(start_c1 || start_r),
        .num(num_x), .den(den_xy), .quo(quo[0]), .done(ldone[0])
    );
    rj_div u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(start_c1 || start_r),
        .num(num_y), .den(den_xy), .quo(quo[1]), .done(ldone[1])
    );
    rj_div u_div_w (
        .aclk(aclk), .aresetn(aresetn), .start(start_c1),
        .num(item_reg.cr), .den(item_reg.c1), .quo(quo[2]), .done(ldone[2])
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (q_valid) state_next = q_data.near ? BK_HOLD : BK_LAUNCH;
            BK_LAUNCH: state_next = BK_ROOT;
            BK_ROOT:   if (ldone[0]) state_next = BK_DIVR;
            BK_DIVR:   if (ldone[0]) state_next = BK_MUL;
            BK_MUL:    if (mcnt_reg == 6'd63) state_next = BK_HOLD;
            BK_HOLD:   if (!m_valid_reg || m_ready) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        start_c1 = 1'b0;
        start_r  = 1'b0;
        mul_load = 1'b0;
        mul_run  = 1'b0;
        out_load = 1'b0;
        sq_init  = 1'b0;
        sq_run   = 1'b0;
        unique case (state_reg)
            BK_IDLE:   q_pop = q_valid;
            BK_LAUNCH: begin
                start_c1 = 1'b1;
                sq_init  = 1'b1;
            end
            BK_ROOT: begin
                start_r = ldone[0];
                sq_run  = sq_cnt_reg != 6'd32;
            end
            BK_DIVR:   mul_load = ldone[0];
            BK_MUL:    mul_run = 1'b1;
            BK_HOLD:   out_load = !m_valid_reg || m_ready;
            default:   q_pop = 1'b0;
        endcase
    end

    assign q_ready = q_pop;

    assign sq_try = sq_res_reg + sq_bit_reg;
    assign sum_a  = {1'b0, acc_a_reg} + {1'b0, sa_a_reg};
    assign sum_b  = {1'b0, acc_b_reg} + {1'b0, sa_b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_data;
        end
        if (sq_init) begin
            sq_n_reg   <= item_reg.s;
            sq_res_reg <= '0;
            sq_bit_reg <= 64'd1 << 62;
            sq_cnt_reg <= '0;
        end else if (sq_run) begin
            if (sq_n_reg >= sq_try) begin
                sq_n_reg   <= sq_n_reg - sq_try;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
            sq_cnt_reg <= sq_cnt_reg + 6'd1;
        end
        if (start_r) begin
            d3_reg <= quo[0];
            d2_reg <= quo[1];
        end
        if (mul_load) begin
            a_reg     <= quo[0];
            b_reg     <= quo[1];
            wsh_reg   <= quo[2];
            sa_a_reg  <= MW'(quo[0]);
            sa_b_reg  <= MW'(quo[1]);
            acc_a_reg <= '0;
            acc_b_reg <= '0;
            ov_a_reg  <= 1'b0;
            ov_b_reg  <= 1'b0;
            sov_a_reg <= 1'b0;
            sov_b_reg <= 1'b0;
            mcnt_reg  <= '0;
        end else if (mul_run) begin
            if (wsh_reg[0]) begin
                acc_a_reg <= sum_a[MW-1:0];
                acc_b_reg <= sum_b[MW-1:0];
                ov_a_reg  <= ov_a_reg || sum_a[MW] || sov_a_reg;
                ov_b_reg  <= ov_b_reg || sum_b[MW] || sov_b_reg;
            end
            sa_a_reg  <= sa_a_reg << 1;
            sa_b_reg  <= sa_b_reg << 1;
            sov_a_reg <= sov_a_reg || sa_a_reg[MW-1];
            sov_b_reg <= sov_b_reg || sa_b_reg[MW-1];
            wsh_reg   <= wsh_reg >> 1;
            mcnt_reg  <= mcnt_reg + 6'd1;
        end
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    assign mag_a = ov_a_reg ? 64'h8000_0000 : 64'(acc_a_reg[MW-1:FRAC_BITS]);
    assign mag_b = ov_b_reg ? 64'h8000_0000 : 64'(acc_b_reg[MW-1:FRAC_BITS]);

    always_comb begin
        if (item_reg.near) begin
            res = '0;
            res.near_zero = 1'b1;
        end else begin
            res.d_range_d_px   = sat32(a_reg, item_reg.npx);
            res.d_range_d_py   = sat32(b_reg, item_reg.npy);
            res.d_bearing_d_px = sat32(d2_reg, !item_reg.npy);
            res.d_bearing_d_py = sat32(d3_reg, item_reg.npx);
            res.d_rate_d_px    = sat32(mag_b, item_reg.npy != item_reg.ncr);
            res.d_rate_d_py    = sat32(mag_a, item_reg.npx == item_reg.ncr);
            res.near_zero      = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_near_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_IDLE && q_valid && q_data.near) |=> state_reg == BK_HOLD)
        else $error("near-zero item did not bypass the arithmetic");
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_c1 |=> !ldone[0] && !ldone[2])
        else $error("divider lanes did not start");
    a_mul_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_MUL && mcnt_reg == 6'd63) |=> state_reg == BK_HOLD)
        else $error("product sequence did not finish after 64 steps");
    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        start_r |-> sq_cnt_reg == 6'd32)
        else $error("division by range started before the root was complete");
`endif

endmodule

// File: hw/rtl/radar_jacobian.sv
// Top level of the radar measurement Jacobian block.
// An item passes through the two front stages and the queue, is loaded into the back, then
// goes through the root with the squared-range division, the division by range, the
// products and the result register. The back takes a new item only when it is through
// with the last one, held up by the bit-serial dividers and multiplier. Near-zero items
// skip the arithmetic and go straight to the result register.
// Reset (aresetn low, synchronous) empties the pipeline and queue, sets the guard to 7.
module radar_jacobian
    import rj_pkg::*;
#(
    parameter int FRAC_BITS = RJ_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rj_in_t      s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rj_out_t     m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // The guard register accepts a transfer on every cycle.
    logic [15:0] guard_reg;
    logic        fq_valid, fq_ready, bq_valid, bq_ready;
    rj_cls_t     fq_data, bq_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg <= RJ_GUARD_RESET;
        end else if (cfg_valid) begin
            guard_reg <= cfg_data;
        end
    end

    // The front squares the position and forms the cross product, so the
    // near-zero decision is made before an item enters the queue.
    rj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .guard(guard_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    // The queue lets the front keep taking items while the back is busy.
    rj_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
    );

    // The back holds its result in an output register, so it can take the
    // next queued item while the result waits for its transfer.
    rj_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// File: dv/tb.sv
// Self-checking testbench for the radar measurement Jacobian block.
module tb;
    import rj_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = RJ_FRAC_BITS;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 220;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    rj_in_t      s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rj_out_t     m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // Expected Jacobian entries, oldest first, and the guard the block should hold.
    rj_out_t     jac_expected[$];
    logic [15:0] guard_shadow = RJ_GUARD_RESET;
    int          mismatch_count = 0;

    // Idle percentages of the two sides, changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // A toggle on hold_go asks the ready process for a long hold-off.
    logic hold_go = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_cnt = 0;

    radar_jacobian dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Integer square root, rounded down, done digit by digit.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Signs a magnitude and clips it to the signed 32-bit range.
    function automatic logic [31:0] clip_signed(input longint unsigned m, input logic neg);
        if (neg) begin
            if (m >= 64'h8000_0000) return 32'h8000_0000;
            return 32'(64'd0 - m);
        end
        if (m > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return m[31:0];
    endfunction

    // Fixed-point product that stops at a value sure to saturate.
    function automatic longint unsigned scaled_product(input longint unsigned a,
                                                       input longint unsigned w);
        longint unsigned lim = 64'd1 << (32 + FB);
        if (a == 0 || w == 0) return 0;
        if (w > lim / a) return lim;
        return (a * w) >> FB;
    endfunction

    // Computes the Jacobian entries expected for one state.
    function automatic rj_out_t predict_jacobian(input rj_in_t st, input logic [15:0] guard);
        rj_out_t         o = '0;
        longint          px = st.pos_x;
        longint          py = st.pos_y;
        longint          vx = st.vel_x;
        longint          vy = st.vel_y;
        logic            npx = px < 0;
        logic            npy = py < 0;
        logic            ncr;
        longint unsigned apx, apy, sq, c1, rng, a, b, cr, w;
        longint          p1, p2;
        apx = npx ? 64'd0 - longint'(px) : px;
        apy = npy ? 64'd0 - longint'(py) : py;
        sq  = apx * apx + apy * apy;
        c1  = sq >> FB;
        if (c1 == 0 || c1 < guard) begin
            o.near_zero = 1'b1;
            return o;
        end
        rng = floor_sqrt(sq);
        a   = (apx << FB) / rng;
        b   = (apy << FB) / rng;
        p1  = vx * py;
        p2  = vy * px;
        ncr = p1 < p2;
        cr  = ncr ? longint'(p2) - longint'(p1) : longint'(p1) - longint'(p2);
        w   = cr / c1;
        o.d_range_d_px   = clip_signed(a, npx);
        o.d_range_d_py   = clip_signed(b, npy);
        o.d_bearing_d_px = clip_signed((apy << FB) / c1, !npy);
        o.d_bearing_d_py = clip_signed((apx << FB) / c1, npx);
        o.d_rate_d_px    = clip_signed(scaled_product(b, w), npy != ncr);
        o.d_rate_d_py    = clip_signed(scaled_product(a, w), npx == ncr);
        return o;
    endfunction

    // Prints one line for a wrong or unexpected result and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // The receiver idles at random, except during a requested hold-off, when it
    // refuses every transfer until hold_cnt, loaded from HOLD_CYCLES, runs out, so the block fills up.
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // Every result transfer is compared field by field with the oldest expectation.
    always @(posedge aclk) begin
        rj_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (jac_expected.size() == 0) begin
                report_mismatch("unexpected result", m_data.d_range_d_px, '0);
            end else begin
                want = jac_expected.pop_front();
                if (m_data.d_range_d_px !== want.d_range_d_px)
                    report_mismatch("d_range_d_px", m_data.d_range_d_px, want.d_range_d_px);
                if (m_data.d_range_d_py !== want.d_range_d_py)
                    report_mismatch("d_range_d_py", m_data.d_range_d_py, want.d_range_d_py);
                if (m_data.d_bearing_d_px !== want.d_bearing_d_px)
                    report_mismatch("d_bearing_d_px", m_data.d_bearing_d_px,
                                    want.d_bearing_d_px);
                if (m_data.d_bearing_d_py !== want.d_bearing_d_py)
                    report_mismatch("d_bearing_d_py", m_data.d_bearing_d_py,
                                    want.d_bearing_d_py);
                if (m_data.d_rate_d_px !== want.d_rate_d_px)
                    report_mismatch("d_rate_d_px", m_data.d_rate_d_px, want.d_rate_d_px);
                if (m_data.d_rate_d_py !== want.d_rate_d_py)
                    report_mismatch("d_rate_d_py", m_data.d_rate_d_py, want.d_rate_d_py);
                if (m_data.near_zero !== want.near_zero)
                    report_mismatch("near_zero", 32'(m_data.near_zero), 32'(want.near_zero));
            end
        end
    end

    // Offers one state and waits for its transfer. Valid stays high from one state
    // to the next unless the sender decides to idle first, so it is never lowered
    // and raised in the same time step.
    task automatic send_state(input rj_in_t st);
        int gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= st;
        do @(posedge aclk); while (!s_ready);
        jac_expected.push_back(predict_jacobian(st, guard_shadow));
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every expected result has come back, then lets the block settle.
    task automatic drain();
        stop_sending();
        while (jac_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the guard register while the block is idle.
    task automatic write_guard(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        guard_shadow = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic rj_in_t make_state(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] vx, input logic [31:0] vy);
        rj_in_t st;
        st.pos_x = px;
        st.pos_y = py;
        st.vel_x = vx;
        st.vel_y = vy;
        return st;
    endfunction

    // A random field: full range, a moderate magnitude, or a value near zero.
    function automatic logic [31:0] random_field();
        int unsigned pick = $urandom_range(9);
        logic [31:0] v = $urandom;
        if (pick < 3) return v;
        if (pick < 8) return 32'($signed(v[23:0]));
        return 32'($signed(v[9:0]));
    endfunction

    // Field extremes, axis-aligned states, the zero state and states on the guard.
    task automatic test_directed();
        send_state(make_state(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000));
        send_state(make_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_state(make_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_state(make_state(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_state(make_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_state(make_state(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000));
        send_state(make_state(32'h0, 32'hFFFF_0000, 32'h0003_0000, 32'h0));
        send_state(make_state(32'h0003_0000, 32'h0004_0000, 32'hFFFE_0000, 32'h0005_8000));
        send_state(make_state(32'hFFFC_0000, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        // Tiny ranges: c1 below and at the reset guard.
        send_state(make_state(32'd676, 32'd0, 32'd100, 32'd100));
        send_state(make_state(32'd678, 32'd0, 32'd100, 32'd100));
        send_state(make_state(32'd1, 32'd256, 32'h8000_0000, 32'h7FFF_FFFF));
        send_state(make_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1));
        // Small ranges with large velocities: the first drives the rate terms into saturation, the second is near zero.
        send_state(make_state(32'd800, 32'hFFFF_FD00, 32'h7FFF_FFFF, 32'h8000_0000));
        send_state(make_state(32'h0000_0100, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000));
    endtask

    // Guard settings at both extremes: zero acts as one, the top refuses small ranges.
    task automatic test_guard();
        write_guard(16'd0);
        send_state(make_state(32'h0, 32'h0, 32'h5, 32'h5));
        send_state(make_state(32'd256, 32'd0, 32'h5, 32'h5));
        send_state(make_state(32'd255, 32'd0, 32'h5, 32'h5));
        write_guard(16'hFFFF);
        send_state(make_state(32'h0000_FFFF, 32'h0, 32'h7, 32'h9));
        send_state(make_state(32'h0001_0000, 32'h0, 32'h7, 32'h9));
        send_state(make_state(32'hFFFF_0000, 32'h0000_0100, 32'h7, 32'h9));
        write_guard(RJ_GUARD_RESET);
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_state(make_state(random_field(), random_field(), random_field(),
                                  random_field()));
    endtask

    // The receiver holds off for a long stretch while states keep coming.
    task automatic test_backpressure();
        int save = send_idle_pct;
        send_idle_pct = 0;
        hold_go = ~hold_go;
        test_random(8);
        send_idle_pct = save;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 34;
        recv_idle_pct = 48;
        test_directed();
        test_guard();
        test_random(150);
        test_backpressure();
        write_guard(16'($urandom_range(1, 65534)));
        send_idle_pct = 48;
        recv_idle_pct = 34;
        test_random(180);
        write_guard(16'($urandom_range(1, 300)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(190);
        drain();

        if (mismatch_count == 0) begin
            $display("radar_jacobian: match");
        end else begin
            $display("radar_jacobian: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #8_000_000;
        $display("radar_jacobian: mismatch");
        $finish;
    end

endmodule
